[hw/rtl/cle_pkg.sv]
// shared types and constants for the connection list expander
`default_nettype none
package cle_pkg;

  localparam int NODE_CAP  = 64;
  localparam int CNT_W     = 7;
  localparam int WORD_W    = 32;
  localparam int VAL_W     = 15;
  localparam int NODE_W    = 8;
  localparam int SEL_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam int SLOT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT  = 2'd2;

  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(NODE_CAP);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic start_run;
    logic skip_entry;
    logic emit_node;
    logic finish_entry;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic emit_ok;
    logic run_end;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/cle_ctrl.sv]
// controller state machine for the connection list expander
`default_nettype none
module cle_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire cle_pkg::status_t status,
  output cle_pkg::cmd_t        cmd
);
  import cle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SLOT;
      end
      ST_SLOT: begin
        if (!status.slot_ok) state_next = ST_FLUSH;
        else if (status.emit_ok) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if ((!status.pend_valid || status.out_free) && status.run_end) state_next = ST_SLOT;
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SLOT: begin
        if (status.slot_ok) begin
          cmd.start_run  = status.emit_ok;
          cmd.skip_entry = !status.emit_ok;
        end
      end
      ST_EMIT: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.emit_node    = 1'b1;
          cmd.finish_entry = status.run_end;
        end
      end
      ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/cle_datapath.sv]
// decode, range expansion and output registers of the connection list expander
`default_nettype none
module cle_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [cle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cle_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic [cle_pkg::WORD_W-1:0]         in_word,
  input  wire logic                               in_start,
  input  wire cle_pkg::cmd_t                      cmd,
  output cle_pkg::status_t                        status,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [cle_pkg::NODE_W-1:0]              out_node,
  output logic [cle_pkg::SEL_W-1:0]               out_sel,
  output logic                                    out_last,
  output logic                                    out_full
);
  import cle_pkg::*;

  logic               wide_mode;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   node_limit;

  logic [WORD_W-1:0]  word;
  logic [SLOT_W-1:0]  slot;
  logic [VAL_W-1:0]   prev;
  logic [CNT_W-1:0]   ncount;
  logic [CNT_W-1:0]   rawidx;
  logic [VAL_W:0]     cur;

  logic               pend_valid;
  logic [NODE_W-1:0]  pend_node;
  logic [SEL_W-1:0]   pend_sel;
  logic               pend_full;

  logic [15:0]        entry;
  logic               is_range;
  logic [VAL_W-1:0]   value;
  logic [VAL_W:0]     first;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   count_next;
  logic               full_next;
  logic               out_free;
  logic               out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode   <= 1'b0;
      entry_count <= '0;
      node_limit  <= LIMIT_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDE_MODE:   wide_mode   <= cfg_data[0];
        CFG_ENTRY_COUNT: entry_count <= cfg_data;
        CFG_NODE_LIMIT:  node_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wide_mode) begin
      entry    = word[{slot[0], 4'b0000} +: 16];
      is_range = entry[15];
      value    = entry[14:0];
    end else begin
      entry    = {8'b0, word[{slot[1:0], 3'b000} +: 8]};
      is_range = entry[7];
      value    = {8'b0, entry[6:0]};
    end
    first      = is_range ? ({1'b0, prev} + 1'b1) : {1'b0, value};
    limit      = (node_limit > LIMIT_MAX) ? LIMIT_MAX : node_limit;
    count_next = ncount + 1'b1;
    full_next  = count_next >= limit;
    out_free   = !out_valid || out_ready;
    out_load   = (cmd.emit_node && pend_valid) || cmd.flush;

    status.slot_ok    = (wide_mode ? (slot < SLOT_W'(2)) : (slot < SLOT_W'(4)))
                        && (rawidx < entry_count);
    status.emit_ok    = (first <= {1'b0, value}) && (ncount < limit);
    status.run_end    = (cur == {1'b0, value}) || full_next;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= in_word;
      slot <= '0;
    end else if (cmd.skip_entry || cmd.finish_entry) begin
      slot <= slot + 1'b1;
    end
    if (cmd.start_run) begin
      cur <= first;
    end else if (cmd.emit_node) begin
      cur <= cur + 1'b1;
    end
    if (cmd.emit_node) begin
      pend_node <= cur[NODE_W-1:0];
      pend_sel  <= ncount[SEL_W-1:0];
      pend_full <= full_next;
    end
    if (out_load) begin
      out_node <= pend_node;
      out_sel  <= pend_sel;
      out_full <= pend_full;
      out_last <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev       <= '0;
      ncount     <= '0;
      rawidx     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load && in_start) begin
        prev   <= '0;
        ncount <= '0;
        rawidx <= '0;
      end else begin
        if (cmd.skip_entry || cmd.finish_entry) begin
          prev   <= value;
          rawidx <= rawidx + 1'b1;
        end
        if (cmd.emit_node) ncount <= count_next;
      end
      if (cmd.emit_node) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("output register overwritten");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    ncount <= LIMIT_MAX) else $error("node count beyond maximum");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_valid) else $error("pending node kept after flush");
  a_emit_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_node |-> (ncount < limit)) else $error("node emitted past limit");
`endif

endmodule
`default_nettype wire

[hw/rtl/connection_list_expander_core.sv]
// top level of the connection list expander
// a word is loaded in idle; then each entry is decoded, and a run yields one node per cycle unless the output stalls
// an entry that yields no node is skipped; end of word is detected, then the pending node, if any, is flushed
// a new word is accepted only after the previous word has been flushed
// the last node of a word is held in a pending stage until flush to mark it tlast
// synchronous active-high rst clears state and sets node_limit to 64
`default_nettype none
module connection_list_expander_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,   // packed_word
  input  wire logic                           s_tuser,   // list_start
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [15:0]                         m_tdata,   // node_id, select_index, zero pad
  output logic                                m_tlast,
  output logic                                m_tuser,   // list_full
  input  wire logic                           cfg_we,
  input  wire logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cle_pkg::CFG_W-1:0]      cfg_data
);
  import cle_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [NODE_W-1:0] node;
  logic [SEL_W-1:0]  sel;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cle_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (s_tdata),
    .in_start  (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_node  (node),
    .out_sel   (sel),
    .out_last  (m_tlast),
    .out_full  (m_tuser)
  );

  assign m_tdata = {2'b00, sel, node};

endmodule
`default_nettype wire
